// ----- rtl/m6502_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502_pkg
// Shared types, opcode codes and the instruction decoder of the 6502 subset.
// ----------------------------------------------------------------------------
package m6502_pkg;

   localparam int MEM_ADDR_BITS_DEF = 16;
   localparam int REQ_TDATA_W       = 32;
   localparam int RSP_TDATA_W       = 72;

   // transaction commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;
   localparam logic [1:0] CMD_EXEC  = 2'd3;

   localparam logic [15:0] VEC_LO_ADDR = 16'hFFFC;
   localparam logic [15:0] VEC_HI_ADDR = 16'hFFFD;
   localparam logic [7:0]  STACK_PAGE  = 8'h01;
   localparam logic [7:0]  SP_RESET    = 8'hFF;

   // opcodes
   localparam logic [7:0] OP_LDA_IMM = 8'hA9;
   localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
   localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
   localparam logic [7:0] OP_LDA_ABS = 8'hAD;
   localparam logic [7:0] OP_LDA_ABX = 8'hBD;
   localparam logic [7:0] OP_LDA_ABY = 8'hB9;
   localparam logic [7:0] OP_LDA_INX = 8'hA1;
   localparam logic [7:0] OP_LDA_INY = 8'hB1;
   localparam logic [7:0] OP_STA_ZP  = 8'h85;
   localparam logic [7:0] OP_STA_ZPX = 8'h95;
   localparam logic [7:0] OP_STA_ABS = 8'h8D;
   localparam logic [7:0] OP_STA_ABX = 8'h9D;
   localparam logic [7:0] OP_STA_ABY = 8'h99;
   localparam logic [7:0] OP_STA_INX = 8'h81;
   localparam logic [7:0] OP_STA_INY = 8'h91;
   localparam logic [7:0] OP_LDX_IMM = 8'hA2;
   localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
   localparam logic [7:0] OP_LDY_IMM = 8'hA0;
   localparam logic [7:0] OP_TAX     = 8'hAA;
   localparam logic [7:0] OP_TXA     = 8'h8A;
   localparam logic [7:0] OP_INX     = 8'hE8;
   localparam logic [7:0] OP_DEX     = 8'hCA;
   localparam logic [7:0] OP_INC_ZP  = 8'hE6;
   localparam logic [7:0] OP_DEC_ZP  = 8'hC6;
   localparam logic [7:0] OP_AND_IMM = 8'h29;
   localparam logic [7:0] OP_ADC_IMM = 8'h69;
   localparam logic [7:0] OP_SBC_IMM = 8'hE9;
   localparam logic [7:0] OP_CMP_IMM = 8'hC9;
   localparam logic [7:0] OP_CMP_ZP  = 8'hC5;
   localparam logic [7:0] OP_CPX_ZP  = 8'hE4;
   localparam logic [7:0] OP_BIT_ZP  = 8'h24;
   localparam logic [7:0] OP_LSR_A   = 8'h4A;
   localparam logic [7:0] OP_CLC     = 8'h18;
   localparam logic [7:0] OP_SEC     = 8'h38;
   localparam logic [7:0] OP_JMP     = 8'h4C;
   localparam logic [7:0] OP_JSR     = 8'h20;
   localparam logic [7:0] OP_RTS     = 8'h60;
   localparam logic [7:0] OP_BEQ     = 8'hF0;
   localparam logic [7:0] OP_BNE     = 8'hD0;
   localparam logic [7:0] OP_BPL     = 8'h10;
   localparam logic [7:0] OP_BCS     = 8'hB0;
   localparam logic [7:0] OP_BCC     = 8'h90;
   localparam logic [7:0] OP_NOP     = 8'hEA;
   localparam logic [7:0] OP_BRK     = 8'h00;

   typedef enum logic [3:0] {
      MODE_IMP, MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ABS, MODE_ABSX, MODE_ABSY,
      MODE_INDX, MODE_INDY, MODE_REL, MODE_JMP, MODE_JSR, MODE_RTS
   } mode_type;

   typedef enum logic [4:0] {
      ALU_NONE, ALU_LDA, ALU_STA, ALU_LDX, ALU_LDY, ALU_TAX, ALU_TXA, ALU_INX,
      ALU_DEX, ALU_INC, ALU_DEC, ALU_AND, ALU_ADC, ALU_SBC, ALU_CMP, ALU_CPX,
      ALU_BIT, ALU_LSR, ALU_CLC, ALU_SEC, ALU_BRK, ALU_BAD
   } alu_type;

   typedef enum logic [3:0] {
      ADDR_REQ, ADDR_PC, ADDR_PTR, ADDR_PTR1, ADDR_EA, ADDR_STK, ADDR_STK1,
      ADDR_VECLO, ADDR_VECHI
   } addr_src_type;

   typedef enum logic [1:0] {WSEL_REQ, WSEL_A, WSEL_RMW, WSEL_PCHI} wsel_type;
   typedef enum logic [1:0] {PC_EAQ, PC_EAQ1, PC_EA, PC_BR} pc_src_type;
   typedef enum logic [1:0] {IDX_NONE, IDX_X, IDX_Y} idx_type;

   typedef struct packed {
      mode_type mode;
      alu_type  alu;
   } decode_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      addr_src_type addr_src;
      logic         mem_we;
      wsel_type     wsel;
      logic         wr_pclo;
      logic         pc_inc;
      logic         pc_load;
      pc_src_type   pc_src;
      logic         sp_inc;
      logic         sp_dec;
      logic         ea_zp;
      logic         ea_zp_x;
      logic         ea_lo;
      logic         ea_hi;
      idx_type      ea_idx;
      logic         ptr_load;
      logic         ptr_add_x;
      logic         exec;
      logic         rdata_load;
      logic         start_load;
      logic         op_load;
      logic         req_load;
      logic         out_load;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] op;
      logic       halted;
      logic       fault;
   } stat_type;

   function automatic decode_type decode(input logic [7:0] op);
      decode_type d;
      unique case (op)
         OP_LDA_IMM: d = '{MODE_IMM,  ALU_LDA};
         OP_LDA_ZP:  d = '{MODE_ZP,   ALU_LDA};
         OP_LDA_ZPX: d = '{MODE_ZPX,  ALU_LDA};
         OP_LDA_ABS: d = '{MODE_ABS,  ALU_LDA};
         OP_LDA_ABX: d = '{MODE_ABSX, ALU_LDA};
         OP_LDA_ABY: d = '{MODE_ABSY, ALU_LDA};
         OP_LDA_INX: d = '{MODE_INDX, ALU_LDA};
         OP_LDA_INY: d = '{MODE_INDY, ALU_LDA};
         OP_STA_ZP:  d = '{MODE_ZP,   ALU_STA};
         OP_STA_ZPX: d = '{MODE_ZPX,  ALU_STA};
         OP_STA_ABS: d = '{MODE_ABS,  ALU_STA};
         OP_STA_ABX: d = '{MODE_ABSX, ALU_STA};
         OP_STA_ABY: d = '{MODE_ABSY, ALU_STA};
         OP_STA_INX: d = '{MODE_INDX, ALU_STA};
         OP_STA_INY: d = '{MODE_INDY, ALU_STA};
         OP_LDX_IMM: d = '{MODE_IMM,  ALU_LDX};
         OP_LDX_ZP:  d = '{MODE_ZP,   ALU_LDX};
         OP_LDY_IMM: d = '{MODE_IMM,  ALU_LDY};
         OP_TAX:     d = '{MODE_IMP,  ALU_TAX};
         OP_TXA:     d = '{MODE_IMP,  ALU_TXA};
         OP_INX:     d = '{MODE_IMP,  ALU_INX};
         OP_DEX:     d = '{MODE_IMP,  ALU_DEX};
         OP_INC_ZP:  d = '{MODE_ZP,   ALU_INC};
         OP_DEC_ZP:  d = '{MODE_ZP,   ALU_DEC};
         OP_AND_IMM: d = '{MODE_IMM,  ALU_AND};
         OP_ADC_IMM: d = '{MODE_IMM,  ALU_ADC};
         OP_SBC_IMM: d = '{MODE_IMM,  ALU_SBC};
         OP_CMP_IMM: d = '{MODE_IMM,  ALU_CMP};
         OP_CMP_ZP:  d = '{MODE_ZP,   ALU_CMP};
         OP_CPX_ZP:  d = '{MODE_ZP,   ALU_CPX};
         OP_BIT_ZP:  d = '{MODE_ZP,   ALU_BIT};
         OP_LSR_A:   d = '{MODE_IMP,  ALU_LSR};
         OP_CLC:     d = '{MODE_IMP,  ALU_CLC};
         OP_SEC:     d = '{MODE_IMP,  ALU_SEC};
         OP_JMP:     d = '{MODE_JMP,  ALU_NONE};
         OP_JSR:     d = '{MODE_JSR,  ALU_NONE};
         OP_RTS:     d = '{MODE_RTS,  ALU_NONE};
         OP_BEQ, OP_BNE, OP_BPL, OP_BCS, OP_BCC: d = '{MODE_REL, ALU_NONE};
         OP_NOP:     d = '{MODE_IMP,  ALU_NONE};
         OP_BRK:     d = '{MODE_IMP,  ALU_BRK};
         default:    d = '{MODE_IMP,  ALU_BAD};
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/m6502_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module m6502_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one access per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/m6502_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502_dp
// Register file, address generation, ALU and result register of the core.
// ----------------------------------------------------------------------------
module m6502_dp
   import m6502_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [1:0]             req_command,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_data,
   output logic [15:0]            mem_addr,
   output logic                   mem_we,
   output logic [7:0]             mem_wdata,
   input  logic [7:0]             mem_q,
   output logic [RSP_TDATA_W-1:0] rsp_word
);

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in;
   logic        c_ff, c_in, z_ff, z_in, v_ff, v_in, n_ff, n_in;
   logic        halt_ff, halt_in, fault_ff, fault_in;
   logic [7:0]  op_ff, op_in, ptr_ff, ptr_in, rdata_ff, rdata_in;
   logic [15:0] ea_ff, ea_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [RSP_TDATA_W-1:0] out_ff, out_in;

   decode_type  dec;
   logic [7:0]  opnd, rmw, cmp_reg, cmp_diff, res;
   logic [8:0]  sum;
   logic [15:0] idx_add, br_target;
   logic        br_take;

   assign dec = decode(op_ff);

   // alu helpers
   always_comb begin
      opnd     = (dec.alu == ALU_SBC) ? ~mem_q : mem_q;
      sum      = {1'b0, a_ff} + {1'b0, opnd} + {8'd0, c_ff};
      rmw      = (dec.alu == ALU_INC) ? 8'(mem_q + 8'd1) : 8'(mem_q - 8'd1);
      cmp_reg  = (dec.alu == ALU_CPX) ? x_ff : a_ff;
      cmp_diff = 8'(cmp_reg - mem_q);
      case (cmd.ea_idx)
         IDX_X:   idx_add = {8'd0, x_ff};
         IDX_Y:   idx_add = {8'd0, y_ff};
         default: idx_add = 16'd0;
      endcase
      case (op_ff)
         OP_BEQ:  br_take = z_ff;
         OP_BNE:  br_take = !z_ff;
         OP_BPL:  br_take = !n_ff;
         OP_BCS:  br_take = c_ff;
         OP_BCC:  br_take = !c_ff;
         default: br_take = 1'b0;
      endcase
      br_target = br_take ? 16'(pc_ff + {{8{mem_q[7]}}, mem_q}) : pc_ff;
   end

   // memory address and write data
   always_comb begin
      unique case (cmd.addr_src)
         ADDR_REQ:   mem_addr = addr_ff;
         ADDR_PC:    mem_addr = pc_ff;
         ADDR_PTR:   mem_addr = {8'h00, ptr_ff};
         ADDR_PTR1:  mem_addr = {8'h00, 8'(ptr_ff + 8'd1)};
         ADDR_EA:    mem_addr = ea_ff;
         ADDR_STK:   mem_addr = {STACK_PAGE, sp_ff};
         ADDR_STK1:  mem_addr = {STACK_PAGE, 8'(sp_ff + 8'd1)};
         ADDR_VECLO: mem_addr = VEC_LO_ADDR;
         ADDR_VECHI: mem_addr = VEC_HI_ADDR;
         default:    mem_addr = pc_ff;
      endcase
      case (cmd.wsel)
         WSEL_REQ:  mem_wdata = data_ff;
         WSEL_A:    mem_wdata = a_ff;
         WSEL_RMW:  mem_wdata = rmw;
         default:   mem_wdata = cmd.wr_pclo ? pc_ff[7:0] : pc_ff[15:8];
      endcase
      mem_we = cmd.mem_we;
   end

   // next-state of the register file
   always_comb begin
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff;
      c_in = c_ff; z_in = z_ff; v_in = v_ff; n_in = n_ff;
      halt_in = halt_ff; fault_in = fault_ff;
      op_in = op_ff; ptr_in = ptr_ff; ea_in = ea_ff; rdata_in = rdata_ff;
      cmd_in = cmd_ff; addr_in = addr_ff; data_in = data_ff; out_in = out_ff;
      res = mem_q;

      if (cmd.req_load) begin
         cmd_in   = req_command;
         addr_in  = req_address;
         data_in  = req_data;
         rdata_in = 8'd0;
      end
      if (cmd.rdata_load) rdata_in = mem_q;
      if (cmd.op_load)    op_in = mem_q;
      if (cmd.ptr_load)   ptr_in = cmd.ptr_add_x ? 8'(mem_q + x_ff) : mem_q;
      if (cmd.ea_zp)      ea_in = {8'h00, cmd.ea_zp_x ? 8'(mem_q + x_ff) : mem_q};
      if (cmd.ea_lo)      ea_in = {ea_ff[15:8], mem_q};
      if (cmd.ea_hi)      ea_in = 16'({mem_q, ea_ff[7:0]} + idx_add);

      // program counter
      if (cmd.pc_inc) begin
         pc_in = 16'(pc_ff + 16'd1);
      end else if (cmd.pc_load) begin
         case (cmd.pc_src)
            PC_EAQ:  pc_in = {mem_q, ea_ff[7:0]};
            PC_EAQ1: pc_in = 16'({mem_q, ea_ff[7:0]} + 16'd1);
            PC_EA:   pc_in = ea_ff;
            default: pc_in = br_target;
         endcase
      end
      if (cmd.sp_inc) sp_in = 8'(sp_ff + 8'd1);
      if (cmd.sp_dec) sp_in = 8'(sp_ff - 8'd1);

      if (cmd.start_load) begin
         sp_in    = SP_RESET;
         halt_in  = 1'b0;
         fault_in = 1'b0;
      end

      // instruction execute
      if (cmd.exec) begin
         case (dec.alu)
            ALU_LDA: begin a_in = mem_q; res = mem_q; end
            ALU_LDX: begin x_in = mem_q; res = mem_q; end
            ALU_LDY: begin y_in = mem_q; res = mem_q; end
            ALU_TAX: begin x_in = a_ff; res = a_ff; end
            ALU_TXA: begin a_in = x_ff; res = x_ff; end
            ALU_INX: begin res = 8'(x_ff + 8'd1); x_in = res; end
            ALU_DEX: begin res = 8'(x_ff - 8'd1); x_in = res; end
            ALU_INC, ALU_DEC: res = rmw;
            ALU_AND: begin res = a_ff & mem_q; a_in = res; end
            ALU_ADC, ALU_SBC: begin
               res  = sum[7:0];
               a_in = res;
               c_in = sum[8];
               v_in = (opnd[7] ^ res[7]) & (res[7] ^ a_ff[7]);
            end
            ALU_CMP, ALU_CPX: begin
               res  = cmp_diff;
               c_in = cmp_reg >= mem_q;
            end
            ALU_LSR: begin
               c_in = a_ff[0];
               res  = {1'b0, a_ff[7:1]};
               a_in = res;
            end
            ALU_CLC: c_in = 1'b0;
            ALU_SEC: c_in = 1'b1;
            ALU_BRK: halt_in = 1'b1;
            ALU_BAD: fault_in = 1'b1;
            default: ;
         endcase
         case (dec.alu)
            ALU_LDA, ALU_LDX, ALU_LDY, ALU_TAX, ALU_TXA, ALU_INX, ALU_DEX, ALU_INC,
            ALU_DEC, ALU_AND, ALU_ADC, ALU_SBC, ALU_CMP, ALU_CPX, ALU_LSR: begin
               z_in = (res == 8'd0);
               n_in = res[7];
            end
            ALU_BIT: begin
               z_in = ((a_ff & mem_q) == 8'd0);
               n_in = mem_q[7];
               v_in = mem_q[6];
            end
            default: ;
         endcase
      end

      if (cmd.out_load) begin
         out_in = {6'd0, fault_ff, halt_ff, n_ff, v_ff, 4'd0, z_ff, c_ff,
                   sp_ff, y_ff, x_ff, a_ff, pc_ff, rdata_ff};
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= 16'd0;
         a_ff     <= 8'd0;
         x_ff     <= 8'd0;
         y_ff     <= 8'd0;
         sp_ff    <= SP_RESET;
         c_ff     <= 1'b0;
         z_ff     <= 1'b0;
         v_ff     <= 1'b0;
         n_ff     <= 1'b0;
         halt_ff  <= 1'b0;
         fault_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         a_ff     <= a_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         sp_ff    <= sp_in;
         c_ff     <= c_in;
         z_ff     <= z_in;
         v_ff     <= v_in;
         n_ff     <= n_in;
         halt_ff  <= halt_in;
         fault_ff <= fault_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ptr_ff   <= ptr_in;
      ea_ff    <= ea_in;
      rdata_ff <= rdata_in;
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      out_ff   <= out_in;
   end

   assign stat     = '{command: cmd_ff, op: op_ff, halted: halt_ff, fault: fault_ff};
   assign rsp_word = out_ff;

endmodule

// ----- rtl/m6502_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m6502_ctrl
// Sequencer that steps each transaction through its memory accesses.
// ----------------------------------------------------------------------------
module m6502_ctrl
   import m6502_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISPATCH = 5'd1;
   localparam logic [4:0] S_RDATA    = 5'd2;
   localparam logic [4:0] S_VEC1     = 5'd3;
   localparam logic [4:0] S_VEC2     = 5'd4;
   localparam logic [4:0] S_OPC      = 5'd5;
   localparam logic [4:0] S_DEC      = 5'd6;
   localparam logic [4:0] S_OPR1     = 5'd7;
   localparam logic [4:0] S_OPR2     = 5'd8;
   localparam logic [4:0] S_JSR      = 5'd9;
   localparam logic [4:0] S_IND0     = 5'd10;
   localparam logic [4:0] S_IND1     = 5'd11;
   localparam logic [4:0] S_IND2     = 5'd12;
   localparam logic [4:0] S_EA       = 5'd13;
   localparam logic [4:0] S_MEM      = 5'd14;
   localparam logic [4:0] S_RTS1     = 5'd15;
   localparam logic [4:0] S_RTS2     = 5'd16;
   localparam logic [4:0] S_DONE     = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;
   decode_type dec;

   assign dec        = decode(stat.op);
   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   // sequencer
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.command)
               CMD_WRITE: begin
                  cmd.addr_src = ADDR_REQ;
                  cmd.mem_we   = 1'b1;
                  cmd.wsel     = WSEL_REQ;
                  state_in     = S_DONE;
               end
               CMD_READ: begin
                  cmd.addr_src = ADDR_REQ;
                  state_in     = S_RDATA;
               end
               CMD_START: begin
                  cmd.addr_src = ADDR_VECLO;
                  state_in     = S_VEC1;
               end
               default: begin
                  if (stat.halted || stat.fault) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.addr_src = ADDR_PC;
                     cmd.pc_inc   = 1'b1;
                     state_in     = S_OPC;
                  end
               end
            endcase
         end
         S_RDATA: begin
            cmd.rdata_load = 1'b1;
            state_in       = S_DONE;
         end
         S_VEC1: begin
            cmd.ea_lo    = 1'b1;
            cmd.addr_src = ADDR_VECHI;
            state_in     = S_VEC2;
         end
         S_VEC2: begin
            cmd.pc_load    = 1'b1;
            cmd.pc_src     = PC_EAQ;
            cmd.start_load = 1'b1;
            state_in       = S_DONE;
         end
         S_OPC: begin
            cmd.op_load = 1'b1;
            state_in    = S_DEC;
         end
         S_DEC: begin
            unique case (dec.mode)
               MODE_IMP: begin
                  cmd.exec = 1'b1;
                  state_in = S_DONE;
               end
               MODE_RTS: begin
                  cmd.addr_src = ADDR_STK1;
                  cmd.sp_inc   = 1'b1;
                  state_in     = S_RTS1;
               end
               default: begin
                  cmd.addr_src = ADDR_PC;
                  cmd.pc_inc   = 1'b1;
                  state_in     = S_OPR1;
               end
            endcase
         end
         S_OPR1: begin
            unique case (dec.mode)
               MODE_IMM: begin
                  cmd.exec = 1'b1;
                  state_in = S_DONE;
               end
               MODE_REL: begin
                  cmd.pc_load = 1'b1;
                  cmd.pc_src  = PC_BR;
                  state_in    = S_DONE;
               end
               MODE_ZP, MODE_ZPX: begin
                  cmd.ea_zp   = 1'b1;
                  cmd.ea_zp_x = (dec.mode == MODE_ZPX);
                  state_in    = S_EA;
               end
               MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_JMP, MODE_JSR: begin
                  cmd.ea_lo    = 1'b1;
                  cmd.addr_src = ADDR_PC;
                  cmd.pc_inc   = (dec.mode != MODE_JSR);
                  state_in     = S_OPR2;
               end
               MODE_INDX, MODE_INDY: begin
                  cmd.ptr_load  = 1'b1;
                  cmd.ptr_add_x = (dec.mode == MODE_INDX);
                  state_in      = S_IND0;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_OPR2: begin
            unique case (dec.mode)
               MODE_JMP: begin
                  cmd.pc_load = 1'b1;
                  cmd.pc_src  = PC_EAQ;
                  state_in    = S_DONE;
               end
               MODE_JSR: begin
                  cmd.ea_hi    = 1'b1;
                  cmd.ea_idx   = IDX_NONE;
                  cmd.addr_src = ADDR_STK;
                  cmd.mem_we   = 1'b1;
                  cmd.wsel     = WSEL_PCHI;
                  cmd.sp_dec   = 1'b1;
                  state_in     = S_JSR;
               end
               default: begin
                  cmd.ea_hi  = 1'b1;
                  cmd.ea_idx = (dec.mode == MODE_ABSX) ? IDX_X :
                               (dec.mode == MODE_ABSY) ? IDX_Y : IDX_NONE;
                  state_in   = S_EA;
               end
            endcase
         end
         S_JSR: begin
            cmd.addr_src = ADDR_STK;
            cmd.mem_we   = 1'b1;
            cmd.wsel     = WSEL_PCHI;
            cmd.wr_pclo  = 1'b1;
            cmd.sp_dec   = 1'b1;
            cmd.pc_load  = 1'b1;
            cmd.pc_src   = PC_EA;
            state_in     = S_DONE;
         end
         S_IND0: begin
            cmd.addr_src = ADDR_PTR;
            state_in     = S_IND1;
         end
         S_IND1: begin
            cmd.ea_lo    = 1'b1;
            cmd.addr_src = ADDR_PTR1;
            state_in     = S_IND2;
         end
         S_IND2: begin
            cmd.ea_hi  = 1'b1;
            cmd.ea_idx = (dec.mode == MODE_INDY) ? IDX_Y : IDX_NONE;
            state_in   = S_EA;
         end
         S_EA: begin
            cmd.addr_src = ADDR_EA;
            if (dec.alu == ALU_STA) begin
               cmd.mem_we = 1'b1;
               cmd.wsel   = WSEL_A;
               state_in   = S_DONE;
            end else begin
               state_in = S_MEM;
            end
         end
         S_MEM: begin
            cmd.exec     = 1'b1;
            cmd.addr_src = ADDR_EA;
            cmd.wsel     = WSEL_RMW;
            cmd.mem_we   = (dec.alu == ALU_INC) || (dec.alu == ALU_DEC);
            state_in     = S_DONE;
         end
         S_RTS1: begin
            cmd.ea_lo    = 1'b1;
            cmd.addr_src = ADDR_STK1;
            cmd.sp_inc   = 1'b1;
            state_in     = S_RTS2;
         end
         S_RTS2: begin
            cmd.pc_load = 1'b1;
            cmd.pc_src  = PC_EAQ1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (cmd.out_load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTH
   // an accepted transaction is always dispatched next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_DISPATCH)
      else $error("accepted transaction not dispatched");

   // the result register is never overwritten while it still waits
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   // no memory write while waiting for a transaction or a result slot
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !cmd.mem_we)
      else $error("memory write outside an active transaction");
`endif

endmodule

// ----- rtl/mini_6502_core_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_6502_core_top
// Subset 6502 core with a 64 KiB byte memory behind a stream interface.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time and answered by one response
// that carries the read byte and all registers after the command. Every
// memory access goes through one single-port RAM with a registered read, so
// the sequencer steps through the accesses one at a time. The response is
// loaded into the output register only once the response slot is free. A
// new request is taken as soon as the previous response is loaded into the
// output register, even if it has not yet been taken.
module mini_6502_core_top
   import m6502_pkg::*;
#(
   parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command[1:0], address[17:2], data[25:18], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[7:0], pc_value[23:8], a_value[31:24], x_value[39:32],
   // y_value[47:40], sp_value[55:48], flags_value[63:56], halted[64],
   // fault[65], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type     cmd;
   stat_type    stat;
   logic [15:0] mem_addr;
   logic        mem_we;
   logic [7:0]  mem_wdata, mem_q;

   m6502_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   m6502_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_tdata[1:0]),
      .req_address (req_tdata[17:2]),
      .req_data    (req_tdata[25:18]),
      .mem_addr    (mem_addr),
      .mem_we      (mem_we),
      .mem_wdata   (mem_wdata),
      .mem_q       (mem_q),
      .rsp_word    (rsp_tdata)
   );

   m6502_ram #(
      .WIDTH (8),
      .DEPTH (1 << MEM_ADDR_BITS)
   ) u_ram (
      .clock (clock),
      .addr  (mem_addr[MEM_ADDR_BITS-1:0]),
      .we    (mem_we),
      .wdata (mem_wdata),
      .rdata (mem_q)
   );

endmodule

// ----- tb/sv/tb_mini_6502_core_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mini_6502_core_top
// Self-checking bench for the 6502 subset core behind its stream ports.
// ----------------------------------------------------------------------------
// A short directed table covers memory extremes, start, halt and fault. It is
// followed by random instruction sequences, each laid down in memory by write
// transactions right before it executes. Operand reads are steered so that
// they only ever touch bytes that were written. Every response is checked
// against an instruction-set predictor or a directed row's fixed value.
module tb_mini_6502_core_top;
   import m6502_pkg::*;

   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          PHASE_ACTIONS  = 50;
   localparam logic [7:0]  OP_UNDEF       = 8'h02;
   localparam logic [7:0]  FL_C = 8'h01, FL_Z = 8'h02, FL_V = 8'h40, FL_N = 8'h80;

   localparam logic [7:0] KNOWN_OPS [44] = '{
      OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_ABS, OP_LDA_ABX, OP_LDA_ABY,
      OP_LDA_INX, OP_LDA_INY, OP_STA_ZP, OP_STA_ZPX, OP_STA_ABS, OP_STA_ABX,
      OP_STA_ABY, OP_STA_INX, OP_STA_INY, OP_LDX_IMM, OP_LDX_ZP, OP_LDY_IMM,
      OP_TAX, OP_TXA, OP_INX, OP_DEX, OP_INC_ZP, OP_DEC_ZP, OP_AND_IMM,
      OP_ADC_IMM, OP_SBC_IMM, OP_CMP_IMM, OP_CMP_ZP, OP_CPX_ZP, OP_BIT_ZP,
      OP_LSR_A, OP_CLC, OP_SEC, OP_JMP, OP_JSR, OP_RTS, OP_BEQ, OP_BNE,
      OP_BPL, OP_BCS, OP_BCC, OP_NOP, OP_BRK
   };

   // response layout, highest field first
   typedef struct packed {
      logic [5:0]  pad;
      logic        fault;
      logic        halted;
      logic [7:0]  flags;
      logic [7:0]  sp;
      logic [7:0]  y;
      logic [7:0]  x;
      logic [7:0]  a;
      logic [15:0] pc;
      logic [7:0]  rdata;
   } core_rsp_type;

   typedef struct {
      logic [1:0]   cmd;
      logic [15:0]  addr;
      logic [7:0]   data;
      bit           typed;
      core_rsp_type want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   mini_6502_core_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------ predictor
   logic [7:0]  mem_img [0:65535];
   bit          mem_known [0:65535];
   logic [15:0] pc_m = '0;
   logic [7:0]  a_m = '0, x_m = '0, y_m = '0, sp_m = SP_RESET, p_m = '0;
   logic        halt_m = 1'b0, fault_m = 1'b0;

   core_rsp_type rsp_due_q [$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_req = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic void poke(input logic [15:0] a, input logic [7:0] v);
      mem_img[a]   = v;
      mem_known[a] = 1'b1;
   endfunction

   function automatic logic [7:0] next_byte();
      logic [7:0] v;
      v    = mem_img[pc_m];
      pc_m = pc_m + 16'd1;
      return v;
   endfunction

   function automatic logic [15:0] next_word();
      logic [7:0] lo;
      lo = next_byte();
      return {next_byte(), lo};
   endfunction

   function automatic logic [15:0] zp_ptr(input logic [7:0] z);
      logic [7:0] z1;
      z1 = z + 8'd1;
      return {mem_img[{8'h00, z1}], mem_img[{8'h00, z}]};
   endfunction

   function automatic void set_zn(input logic [7:0] v);
      p_m = (v == 8'h00) ? (p_m | FL_Z) : (p_m & ~FL_Z);
      p_m = v[7] ? (p_m | FL_N) : (p_m & ~FL_N);
   endfunction

   function automatic void load_a(input logic [7:0] v);
      a_m = v;
      set_zn(v);
   endfunction

   function automatic void add_carry(input logic [7:0] m);
      logic [8:0] s;
      logic [7:0] r;
      s   = {1'b0, a_m} + {1'b0, m} + {8'h00, p_m[0]};
      r   = s[7:0];
      p_m = s[8] ? (p_m | FL_C) : (p_m & ~FL_C);
      p_m = ((m ^ r) & (r ^ a_m) & 8'h80) != 0 ? (p_m | FL_V) : (p_m & ~FL_V);
      load_a(r);
   endfunction

   function automatic void compare(input logic [7:0] r, input logic [7:0] v);
      logic [7:0] d;
      d   = r - v;
      p_m = (r >= v) ? (p_m | FL_C) : (p_m & ~FL_C);
      set_zn(d);
   endfunction

   function automatic void branch(input bit take);
      logic [7:0] off;
      off = next_byte();
      if (take) pc_m = pc_m + {{8{off[7]}}, off};
   endfunction

   function automatic void push(input logic [7:0] v);
      poke({STACK_PAGE, sp_m}, v);
      sp_m = sp_m - 8'd1;
   endfunction

   function automatic logic [7:0] pop();
      sp_m = sp_m + 8'd1;
      return mem_img[{STACK_PAGE, sp_m}];
   endfunction

   // effective addresses of the memory modes
   function automatic logic [15:0] ea_zpx();
      logic [7:0] z;
      z = next_byte() + x_m;
      return {8'h00, z};
   endfunction

   function automatic logic [15:0] ea_indx();
      logic [7:0] z;
      z = next_byte() + x_m;
      return zp_ptr(z);
   endfunction

   function automatic logic [15:0] ea_indy();
      return zp_ptr(next_byte()) + {8'h00, y_m};
   endfunction

   function automatic void run_instr();
      logic [7:0]  op, v;
      logic [15:0] ea, t;
      op = next_byte();
      case (op)
         OP_LDA_IMM: load_a(next_byte());
         OP_LDA_ZP:  load_a(mem_img[{8'h00, next_byte()}]);
         OP_LDA_ZPX: load_a(mem_img[ea_zpx()]);
         OP_LDA_ABS: load_a(mem_img[next_word()]);
         OP_LDA_ABX: load_a(mem_img[next_word() + {8'h00, x_m}]);
         OP_LDA_ABY: load_a(mem_img[next_word() + {8'h00, y_m}]);
         OP_LDA_INX: load_a(mem_img[ea_indx()]);
         OP_LDA_INY: load_a(mem_img[ea_indy()]);
         OP_STA_ZP:  poke({8'h00, next_byte()}, a_m);
         OP_STA_ZPX: poke(ea_zpx(), a_m);
         OP_STA_ABS: poke(next_word(), a_m);
         OP_STA_ABX: poke(next_word() + {8'h00, x_m}, a_m);
         OP_STA_ABY: poke(next_word() + {8'h00, y_m}, a_m);
         OP_STA_INX: poke(ea_indx(), a_m);
         OP_STA_INY: poke(ea_indy(), a_m);
         OP_LDX_IMM: begin x_m = next_byte(); set_zn(x_m); end
         OP_LDX_ZP:  begin x_m = mem_img[{8'h00, next_byte()}]; set_zn(x_m); end
         OP_LDY_IMM: begin y_m = next_byte(); set_zn(y_m); end
         OP_TAX:     begin x_m = a_m; set_zn(x_m); end
         OP_TXA:     load_a(x_m);
         OP_INX:     begin x_m = x_m + 8'd1; set_zn(x_m); end
         OP_DEX:     begin x_m = x_m - 8'd1; set_zn(x_m); end
         OP_INC_ZP, OP_DEC_ZP: begin
            ea = {8'h00, next_byte()};
            v  = (op == OP_INC_ZP) ? mem_img[ea] + 8'd1 : mem_img[ea] - 8'd1;
            poke(ea, v);
            set_zn(v);
         end
         OP_AND_IMM: load_a(next_byte() & a_m);
         OP_ADC_IMM: add_carry(next_byte());
         OP_SBC_IMM: add_carry(~next_byte());
         OP_CMP_IMM: compare(a_m, next_byte());
         OP_CMP_ZP:  compare(a_m, mem_img[{8'h00, next_byte()}]);
         OP_CPX_ZP:  compare(x_m, mem_img[{8'h00, next_byte()}]);
         OP_BIT_ZP: begin
            v   = mem_img[{8'h00, next_byte()}];
            p_m = ((a_m & v) == 8'h00) ? (p_m | FL_Z) : (p_m & ~FL_Z);
            p_m = (p_m & ~(FL_N | FL_V)) | (v & (FL_N | FL_V));
         end
         OP_LSR_A: begin
            p_m = a_m[0] ? (p_m | FL_C) : (p_m & ~FL_C);
            load_a(a_m >> 1);
         end
         OP_CLC: p_m = p_m & ~FL_C;
         OP_SEC: p_m = p_m | FL_C;
         OP_JMP: begin
            t    = pc_m + 16'd1;
            pc_m = {mem_img[t], mem_img[pc_m]};
         end
         OP_JSR: begin
            t  = pc_m + 16'd1;
            ea = {mem_img[t], mem_img[pc_m]};
            push(t[15:8]);
            push(t[7:0]);
            pc_m = ea;
         end
         OP_RTS: begin
            t[7:0]  = pop();
            t[15:8] = pop();
            pc_m    = t + 16'd1;
         end
         OP_BEQ: branch(p_m[1]);
         OP_BNE: branch(!p_m[1]);
         OP_BPL: branch(!p_m[7]);
         OP_BCS: branch(p_m[0]);
         OP_BCC: branch(!p_m[0]);
         OP_NOP: ;
         OP_BRK: halt_m = 1'b1;
         default: fault_m = 1'b1;
      endcase
   endfunction

   function automatic core_rsp_type core_step(input logic [1:0] cmd,
                                              input logic [15:0] addr,
                                              input logic [7:0] data);
      core_rsp_type r;
      r = '0;
      case (cmd)
         CMD_WRITE: poke(addr, data);
         CMD_READ:  r.rdata = mem_img[addr];
         CMD_START: begin
            pc_m    = {mem_img[VEC_HI_ADDR], mem_img[VEC_LO_ADDR]};
            sp_m    = SP_RESET;
            halt_m  = 1'b0;
            fault_m = 1'b0;
         end
         default: if (!halt_m && !fault_m) run_instr();
      endcase
      r.pc     = pc_m;
      r.a      = a_m;
      r.x      = x_m;
      r.y      = y_m;
      r.sp     = sp_m;
      r.flags  = p_m & (FL_C | FL_Z | FL_V | FL_N);
      r.halted = halt_m;
      r.fault  = fault_m;
      return r;
   endfunction

   // ------------------------------------------------------------ request side
   task automatic send(input logic [1:0] cmd, input logic [15:0] addr, input logic [7:0] data,
                       input bit typed = 1'b0, input core_rsp_type want = '0);
      core_rsp_type e;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, data, addr, cmd};
      do @(posedge clock); while (!req_tready);
      e = core_step(cmd, addr, data);
      rsp_due_q.push_back(typed ? want : e);
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   function automatic bit is_known_op(input logic [7:0] op);
      foreach (KNOWN_OPS[i]) if (KNOWN_OPS[i] == op) return 1'b1;
      return 1'b0;
   endfunction

   // lay one random instruction down at the pc and execute it
   task automatic issue_instr();
      logic [7:0]  op, b1, b2, z;
      logic [15:0] ea, tgt;
      // keep the program out of page zero and the stack page
      if (pc_m < 16'h0200) begin
         tgt = 16'($urandom_range(16'h0400, 16'hEFFF));
         send(CMD_WRITE, pc_m, OP_JMP);
         send(CMD_WRITE, pc_m + 16'd1, tgt[7:0]);
         send(CMD_WRITE, pc_m + 16'd2, tgt[15:8]);
         send(CMD_EXEC, 16'($urandom), 8'($urandom));
         if (pc_m < 16'h0200) return;
      end
      op = KNOWN_OPS[$urandom_range(0, 43)];
      if ($urandom_range(0, 43) == 0) begin
         do op = 8'($urandom); while (is_known_op(op));
      end
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      // steer loads onto written bytes
      case (op)
         OP_LDA_ABS, OP_LDA_ABX, OP_LDA_ABY: begin
            ea = {b2, b1} + ((op == OP_LDA_ABX) ? {8'h00, x_m} :
                             (op == OP_LDA_ABY) ? {8'h00, y_m} : 16'h0000);
            if (!mem_known[ea]) begin
               b1 = 8'($urandom);
               b2 = 8'h00;
            end
         end
         OP_LDA_INX, OP_LDA_INY: begin
            z  = (op == OP_LDA_INX) ? b1 + x_m : b1;
            ea = zp_ptr(z) + ((op == OP_LDA_INY) ? {8'h00, y_m} : 16'h0000);
            if (!mem_known[ea]) begin
               send(CMD_WRITE, {8'h00, z}, 8'($urandom));
               send(CMD_WRITE, {8'h00, z + 8'd1}, 8'h00);
            end
         end
         default: ;
      endcase
      send(CMD_WRITE, pc_m, op);
      send(CMD_WRITE, pc_m + 16'd1, b1);
      send(CMD_WRITE, pc_m + 16'd2, b2);
      send(CMD_EXEC, 16'($urandom), 8'($urandom));
   endtask

   // ------------------------------------------------------------ response side
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req   <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      core_rsp_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = core_rsp_type'(rsp_tdata);
         if (rsp_due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp = rsp_due_q.pop_front();
            if (got !== exp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response mismatch\n",
                            "  exp rd=%h pc=%h a=%h x=%h y=%h sp=%h p=%h hlt=%b flt=%b pad=%h\n",
                            "  got rd=%h pc=%h a=%h x=%h y=%h sp=%h p=%h hlt=%b flt=%b pad=%h"},
                           exp.rdata, exp.pc, exp.a, exp.x, exp.y, exp.sp, exp.flags,
                           exp.halted, exp.fault, exp.pad,
                           got.rdata, got.pc, got.a, got.x, got.y, got.sp, got.flags,
                           got.halted, got.fault, got.pad);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ------------------------------------------------------------ stimulus
   localparam core_rsp_type RST_RSP = '{6'd0, 1'b0, 1'b0, 8'h00, SP_RESET, 8'h00, 8'h00,
                                        8'h00, 16'h0000, 8'h00};

   stim_row_type directed [23];
   int        phase_idle  [5] = '{0, 54, 0, 35, 0};
   int        phase_stall [5] = '{0, 0, 54, 35, 0};

   initial begin
      core_rsp_type w;
      int        r;
      // memory extremes, start, flag corners, halt and fault
      directed[0]  = '{CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, RST_RSP};
      directed[1]  = '{CMD_WRITE, 16'h0000, 8'h00, 1'b1, RST_RSP};
      w = RST_RSP; w.rdata = 8'hFF;
      directed[2]  = '{CMD_READ,  16'hFFFF, 8'h00, 1'b1, w};
      directed[3]  = '{CMD_READ,  16'h0000, 8'hFF, 1'b1, RST_RSP};
      directed[4]  = '{CMD_WRITE, VEC_LO_ADDR, 8'h00, 1'b0, '0};
      directed[5]  = '{CMD_WRITE, VEC_HI_ADDR, 8'h02, 1'b0, '0};
      w = RST_RSP; w.pc = 16'h0200;
      directed[6]  = '{CMD_START, 16'h0000, 8'h00, 1'b1, w};
      directed[7]  = '{CMD_WRITE, 16'h0200, OP_LDA_IMM, 1'b0, '0};
      directed[8]  = '{CMD_WRITE, 16'h0201, 8'h80, 1'b0, '0};
      directed[9]  = '{CMD_WRITE, 16'h0202, OP_ADC_IMM, 1'b0, '0};
      directed[10] = '{CMD_WRITE, 16'h0203, 8'h80, 1'b0, '0};
      directed[11] = '{CMD_WRITE, 16'h0204, OP_LSR_A, 1'b0, '0};
      directed[12] = '{CMD_WRITE, 16'h0205, OP_BRK, 1'b0, '0};
      directed[13] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      directed[14] = '{CMD_EXEC,  16'hFFFF, 8'hFF, 1'b0, '0};
      directed[15] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      directed[16] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      // execute while halted changes nothing
      directed[17] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      directed[18] = '{CMD_START, 16'h0000, 8'h00, 1'b0, '0};
      directed[19] = '{CMD_WRITE, 16'h0200, OP_UNDEF, 1'b0, '0};
      directed[20] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      directed[21] = '{CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0};
      directed[22] = '{CMD_START, 16'h0000, 8'h00, 1'b0, '0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send(directed[i].cmd, directed[i].addr, directed[i].data,
              directed[i].typed, directed[i].want);
      wait_drained();

      // fill page zero and the stack page so operand reads stay defined
      for (int a = 0; a < 16'h0200; a++) send(CMD_WRITE, a[15:0], 8'($urandom));
      wait_drained();

      // random phases with different idle and stall mixes
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct  = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         for (int n = 0; n < PHASE_ACTIONS; n++) begin
            if (ph == 0 && n == 10) hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if ((halt_m || fault_m) && r < 50)
               send(CMD_START, 16'($urandom), 8'($urandom));
            else if (r < 8)
               send(CMD_WRITE, 16'($urandom), 8'($urandom));
            else if (r < 16) begin
               w.pc = 16'($urandom);
               if (!mem_known[w.pc]) w.pc = 16'($urandom_range(0, 16'h01FF));
               send(CMD_READ, w.pc, 8'($urandom));
            end else if (r < 19)
               send(CMD_START, 16'($urandom), 8'($urandom));
            else
               issue_instr();
         end
         wait_drained();
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && rsp_due_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
